>>> hw/rtl/lz_block_decompressor_assert.svh
// assertion macros used by the checker file
`ifndef LZ_BLOCK_DECOMPRESSOR_ASSERT_SVH
`define LZ_BLOCK_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication
`define LZBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lz block decompressor check failed");

// next-cycle implication
`define LZBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lz block decompressor check failed");

`endif

>>> hw/rtl/lzbd_pkg.sv
// shared types and codes of the lz block decompressor
package lzbd_pkg;

    localparam int DATA_W  = 8;
    localparam int TOTAL_W = 24;
    localparam int CODE_W  = 3;
    localparam int SIZE_W  = 16;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_STORED,
        PH_TAG,
        PH_LITERAL,
        PH_MATCH,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_DONE,
        KIND_ERROR
    } t_kind;

    localparam logic [CODE_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [CODE_W-1:0] ERR_ZERO_SIZE = 3'd1;
    localparam logic [CODE_W-1:0] ERR_CAPACITY  = 3'd2;
    localparam logic [CODE_W-1:0] ERR_TRUNCATED = 3'd3;
    localparam logic [CODE_W-1:0] ERR_OFFSET    = 3'd4;
    localparam logic [CODE_W-1:0] ERR_TOKEN     = 3'd5;
    localparam logic [CODE_W-1:0] ERR_LENGTH    = 3'd6;

    localparam logic [TOTAL_W-1:0] CAP_RESET = 24'hFFFFFF;

endpackage

>>> hw/rtl/lzbd_ram.sv
// generic single-write single-read ram with registered read data
module lzbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/lz_block_decompressor.sv
// top level of the lz block decompressor
// Streaming decoder for a block-LZ container, one container byte per input
// transaction. An item that yields a data byte and also closes a run (error
// or done) sends the closing result after the data byte. A match token's
// second byte starts a copy of MIN_MATCH to 15 + MIN_MATCH bytes, followed
// by any trailing error or done result: the copy goes through the single
// read port of the history ram, one byte a cycle while the output register
// is free, with the just-written byte forwarded for overlapping copies.
// The history needs no clearing after reset, so the block is ready at once.
// A new item is taken only while the output register is empty or being read
// in the same cycle, so a result left waiting holds the input off.
// The user must write output_capacity through the cfg channel only while idle; the block does not enforce it.
module lz_block_decompressor #(
    parameter int HISTORY_DEPTH = 2048,
    parameter int MIN_MATCH     = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lzbd_pkg::TOTAL_W-1:0]  i_cfg_output_capacity,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lzbd_pkg::DATA_W-1:0]   i_in_byte,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_kind,
    output logic [lzbd_pkg::DATA_W-1:0]   o_out_byte,
    output logic [lzbd_pkg::CODE_W-1:0]   o_error_code,
    output logic [lzbd_pkg::TOTAL_W-1:0]  o_total_length,
    output logic                          o_last_of_run
);
    import lzbd_pkg::*;

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int LEN_W = $clog2(15 + MIN_MATCH + 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

    // stream state
    t_phase              r_phase, n_phase;
    logic [1:0]          r_hidx;
    logic [SIZE_W-1:0]   r_raw, r_packed, r_consumed, r_bw;
    logic [TOTAL_W-1:0]  r_total, r_cap;
    logic [6:0]          r_litrem;
    logic [7:0]          r_mtag;
    logic                r_failed;
    logic [CODE_W-1:0]   r_serr;

    // history pointers and copy engine
    logic [AW-1:0]       r_wptr, r_rptr, n_rptr;
    logic                r_copy_act;
    logic [LEN_W-1:0]    r_copy_cnt;
    logic                r_fwd_hit;
    logic [DATA_W-1:0]   r_fwd_data;

    // pending closing result
    logic                r_tail_pend;
    t_kind               r_tail_kind;
    logic [CODE_W-1:0]   r_tail_code;
    logic [TOTAL_W-1:0]  r_tail_total;

    // output register
    logic                r_o_valid;
    t_kind               r_o_kind;
    logic [DATA_W-1:0]   r_o_byte;
    logic [CODE_W-1:0]   r_o_code;
    logic [TOTAL_W-1:0]  r_o_total;
    logic                r_o_last;

    // decode of the incoming byte
    t_phase              dec_phase;
    logic [1:0]          dec_hidx;
    logic [SIZE_W-1:0]   dec_raw, dec_packed, dec_consumed, dec_bw, cons_inc;
    logic [TOTAL_W-1:0]  dec_total;
    logic [6:0]          dec_litrem;
    logic [7:0]          dec_mtag;
    logic                dec_err_v, dec_byte_v, dec_copy_v, dec_new_block, dec_eot;
    logic [CODE_W-1:0]   dec_err_code, dec_serr, done_code;
    logic                dec_failed;
    logic [10:0]         match_off;
    logic [LEN_W-1:0]    match_len;
    logic [AW:0]         base_diff;
    logic [AW-1:0]       copy_base;

    // control
    logic                out_load_ok, in_ready, acc, copy_emit, tail_emit;
    logic                tail_v;
    t_kind               tail_kind;
    logic [CODE_W-1:0]   tail_code;
    logic [TOTAL_W-1:0]  tail_total;
    logic                ram_we;
    logic [DATA_W-1:0]   ram_wdata, ram_rdata, copy_byte;
    logic [AW-1:0]       wptr_inc, rptr_inc;

    assign match_off = {r_mtag[2:0], i_in_byte};
    assign match_len = LEN_W'(r_mtag[6:3]) + LEN_W'(MIN_MATCH);
    assign cons_inc  = r_consumed + 16'd1;
    assign base_diff = {1'b0, r_wptr} - (AW+1)'(match_off);
    assign copy_base = base_diff[AW] ? AW'(base_diff + DEPTH_EXT) : base_diff[AW-1:0];

    always_comb begin
        dec_phase     = r_phase;
        dec_hidx      = r_hidx;
        dec_raw       = r_raw;
        dec_packed    = r_packed;
        dec_consumed  = r_consumed;
        dec_bw        = r_bw;
        dec_total     = r_total;
        dec_litrem    = r_litrem;
        dec_mtag      = r_mtag;
        dec_err_v     = 1'b0;
        dec_err_code  = ERR_NONE;
        dec_byte_v    = 1'b0;
        dec_copy_v    = 1'b0;
        dec_new_block = 1'b0;
        dec_eot       = 1'b0;
        if (!r_failed) begin
            unique case (r_phase)
                PH_HEADER: begin
                    unique case (r_hidx)
                        2'd0: dec_raw    = {8'h00, i_in_byte};
                        2'd1: dec_raw    = {i_in_byte, r_raw[7:0]};
                        2'd2: dec_packed = {8'h00, i_in_byte};
                        2'd3: dec_packed = {i_in_byte, r_packed[7:0]};
                    endcase
                    if (r_hidx != 2'd3) begin
                        dec_hidx = r_hidx + 2'd1;
                    end else begin
                        dec_hidx = 2'd0;
                        if (dec_packed == '0) begin
                            dec_err_v    = 1'b1;
                            dec_err_code = ERR_ZERO_SIZE;
                        end else if (({1'b0, r_total} + 25'(dec_raw)) > {1'b0, r_cap}) begin
                            dec_err_v    = 1'b1;
                            dec_err_code = ERR_CAPACITY;
                        end else begin
                            dec_new_block = 1'b1;
                            dec_bw        = '0;
                            dec_consumed  = '0;
                            dec_phase     = (dec_raw == dec_packed) ? PH_STORED : PH_TAG;
                        end
                    end
                end
                PH_STORED: begin
                    dec_consumed = cons_inc;
                    if (({1'b0, r_total} + 25'd1) > {1'b0, r_cap}) begin
                        dec_err_v    = 1'b1;
                        dec_err_code = ERR_CAPACITY;
                    end else begin
                        dec_byte_v = 1'b1;
                        dec_bw     = r_bw + 16'd1;
                        dec_total  = r_total + 24'd1;
                        if (cons_inc >= r_packed) begin
                            dec_phase = PH_HEADER;
                        end
                    end
                end
                PH_TAG: begin
                    dec_consumed = cons_inc;
                    if (i_in_byte[7]) begin
                        if (cons_inc >= r_packed) begin
                            dec_err_v    = 1'b1;
                            dec_err_code = ERR_TOKEN;
                        end else begin
                            dec_mtag  = i_in_byte;
                            dec_phase = PH_MATCH;
                        end
                    end else if (i_in_byte == '0) begin
                        if (r_bw != r_raw) begin
                            dec_err_v    = 1'b1;
                            dec_err_code = ERR_LENGTH;
                        end else begin
                            dec_phase = (cons_inc >= r_packed) ? PH_HEADER : PH_SKIP;
                        end
                    end else if (({1'b0, cons_inc} + 17'(i_in_byte)) > {1'b0, r_packed}) begin
                        dec_err_v    = 1'b1;
                        dec_err_code = ERR_TOKEN;
                    end else if (({1'b0, r_total} + 25'(i_in_byte)) > {1'b0, r_cap}) begin
                        dec_err_v    = 1'b1;
                        dec_err_code = ERR_CAPACITY;
                    end else if (({1'b0, r_bw} + 17'(i_in_byte)) > {1'b0, r_raw}) begin
                        dec_err_v    = 1'b1;
                        dec_err_code = ERR_LENGTH;
                    end else begin
                        dec_litrem = i_in_byte[6:0];
                        dec_phase  = PH_LITERAL;
                    end
                end
                PH_LITERAL: begin
                    dec_consumed = cons_inc;
                    dec_byte_v   = 1'b1;
                    dec_bw       = r_bw + 16'd1;
                    dec_total    = r_total + 24'd1;
                    dec_litrem   = r_litrem - 7'd1;
                    dec_eot      = (dec_litrem == '0);
                end
                PH_MATCH: begin
                    dec_consumed = cons_inc;
                    if (match_off == '0 || 16'(match_off) > r_bw) begin
                        dec_err_v    = 1'b1;
                        dec_err_code = ERR_OFFSET;
                    end else if (({1'b0, r_total} + 25'(match_len)) > {1'b0, r_cap}) begin
                        dec_err_v    = 1'b1;
                        dec_err_code = ERR_CAPACITY;
                    end else if (({1'b0, r_bw} + 17'(match_len)) > {1'b0, r_raw}) begin
                        dec_err_v    = 1'b1;
                        dec_err_code = ERR_LENGTH;
                    end else begin
                        dec_copy_v = 1'b1;
                        dec_bw     = r_bw + 16'(match_len);
                        dec_total  = r_total + 24'(match_len);
                        dec_eot    = 1'b1;
                    end
                end
                PH_SKIP: begin
                    dec_consumed = cons_inc;
                    if (cons_inc >= r_packed) begin
                        dec_phase = PH_HEADER;
                    end
                end
                default: ;
            endcase
            // end of a literal run or match
            if (dec_eot) begin
                if (cons_inc >= r_packed) begin
                    if (dec_bw != r_raw) begin
                        dec_err_v    = 1'b1;
                        dec_err_code = ERR_LENGTH;
                    end else begin
                        dec_phase = PH_HEADER;
                    end
                end else begin
                    dec_phase = PH_TAG;
                end
            end
        end
        dec_failed = r_failed | dec_err_v;
        dec_serr   = (dec_err_v && r_serr == ERR_NONE) ? dec_err_code : r_serr;
        done_code  = (dec_serr == ERR_NONE && !dec_failed && dec_phase != PH_HEADER)
                   ? ERR_TRUNCATED : dec_serr;
    end

    // handshake and result selection
    assign out_load_ok = !r_o_valid || i_out_ready;
    assign in_ready    = !r_copy_act && !r_tail_pend && out_load_ok;
    assign acc         = i_in_valid && in_ready;
    assign copy_emit   = r_copy_act && out_load_ok;
    assign tail_emit   = !r_copy_act && r_tail_pend && out_load_ok;

    assign tail_v     = i_last || dec_err_v;
    assign tail_kind  = i_last ? KIND_DONE : KIND_ERROR;
    assign tail_code  = i_last ? done_code : dec_err_code;
    assign tail_total = i_last ? dec_total : '0;

    assign copy_byte = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign ram_we    = (acc && dec_byte_v) || copy_emit;
    assign ram_wdata = copy_emit ? copy_byte : i_in_byte;
    assign wptr_inc  = (r_wptr == LAST_ADDR) ? '0 : r_wptr + AW'(1);
    assign rptr_inc  = (r_rptr == LAST_ADDR) ? '0 : r_rptr + AW'(1);

    always_comb begin
        n_rptr = r_rptr;
        if (acc && dec_copy_v) begin
            n_rptr = copy_base;
        end else if (copy_emit) begin
            n_rptr = rptr_inc;
        end
        n_phase = r_phase;
        if (acc) begin
            n_phase = i_last ? PH_HEADER : dec_phase;
        end
    end

    lzbd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (ram_wdata),
        .i_raddr (n_rptr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx      <= '0;
            r_raw       <= '0;
            r_packed    <= '0;
            r_consumed  <= '0;
            r_bw        <= '0;
            r_total     <= '0;
            r_litrem    <= '0;
            r_mtag      <= '0;
            r_failed    <= 1'b0;
            r_serr      <= ERR_NONE;
            r_cap       <= CAP_RESET;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_copy_act  <= 1'b0;
            r_copy_cnt  <= '0;
            r_fwd_hit   <= 1'b0;
            r_tail_pend <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_output_capacity;
            end
            r_rptr    <= n_rptr;
            r_fwd_hit <= ram_we && (r_wptr == n_rptr);
            if (ram_we) begin
                r_wptr <= wptr_inc;
            end
            if (acc) begin
                if (i_last) begin
                    r_hidx     <= '0;
                    r_raw      <= '0;
                    r_packed   <= '0;
                    r_consumed <= '0;
                    r_bw       <= '0;
                    r_total    <= '0;
                    r_litrem   <= '0;
                    r_mtag     <= '0;
                    r_failed   <= 1'b0;
                    r_serr     <= ERR_NONE;
                end else begin
                    r_hidx     <= dec_hidx;
                    r_raw      <= dec_raw;
                    r_packed   <= dec_packed;
                    r_consumed <= dec_consumed;
                    r_bw       <= dec_bw;
                    r_total    <= dec_total;
                    r_litrem   <= dec_litrem;
                    r_mtag     <= dec_mtag;
                    r_failed   <= dec_failed;
                    r_serr     <= dec_serr;
                end
                if (dec_new_block) begin
                    r_wptr <= '0;
                end
                if (dec_copy_v) begin
                    r_copy_act <= 1'b1;
                    r_copy_cnt <= match_len;
                end
                r_tail_pend <= tail_v && (dec_byte_v || dec_copy_v);
            end
            if (copy_emit) begin
                r_copy_cnt <= r_copy_cnt - LEN_W'(1);
                if (r_copy_cnt == LEN_W'(1)) begin
                    r_copy_act <= 1'b0;
                end
            end
            if (tail_emit) begin
                r_tail_pend <= 1'b0;
            end
            if (copy_emit || tail_emit || (acc && (dec_byte_v || (!dec_copy_v && tail_v)))) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fwd_data <= ram_wdata;
        if (acc) begin
            r_tail_kind  <= tail_kind;
            r_tail_code  <= tail_code;
            r_tail_total <= tail_total;
        end
        if (copy_emit) begin
            r_o_kind  <= KIND_DATA;
            r_o_byte  <= copy_byte;
            r_o_code  <= ERR_NONE;
            r_o_total <= '0;
            r_o_last  <= (r_copy_cnt == LEN_W'(1)) && !r_tail_pend;
        end else if (tail_emit) begin
            r_o_kind  <= r_tail_kind;
            r_o_byte  <= '0;
            r_o_code  <= r_tail_code;
            r_o_total <= r_tail_total;
            r_o_last  <= 1'b1;
        end else if (acc && dec_byte_v) begin
            r_o_kind  <= KIND_DATA;
            r_o_byte  <= i_in_byte;
            r_o_code  <= ERR_NONE;
            r_o_total <= '0;
            r_o_last  <= !tail_v;
        end else if (acc && !dec_copy_v && tail_v) begin
            r_o_kind  <= tail_kind;
            r_o_byte  <= '0;
            r_o_code  <= tail_code;
            r_o_total <= tail_total;
            r_o_last  <= 1'b1;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = in_ready;
    assign o_out_valid    = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_out_byte     = r_o_byte;
    assign o_error_code   = r_o_code;
    assign o_total_length = r_o_total;
    assign o_last_of_run  = r_o_last;

endmodule

>>> hw/rtl/lzbd_checker.sv
// port-level checker for the lz block decompressor and its bind
`include "lz_block_decompressor_assert.svh"

module lzbd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [lzbd_pkg::TOTAL_W-1:0]  i_cfg_output_capacity,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [lzbd_pkg::DATA_W-1:0]   i_in_byte,
    input logic                          i_last,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [1:0]                    o_kind,
    input logic [lzbd_pkg::DATA_W-1:0]   o_out_byte,
    input logic [lzbd_pkg::CODE_W-1:0]   o_error_code,
    input logic [lzbd_pkg::TOTAL_W-1:0]  o_total_length,
    input logic                          o_last_of_run
);
    import lzbd_pkg::*;

    // a stalled result holds
    `LZBD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_kind) && $stable(o_out_byte) && $stable(o_total_length))

    // no new transaction while the output register is blocked
    `LZBD_ASSERT_NOW(a_in_blocked, o_out_valid && !i_out_ready, !o_in_ready)

    // done and error results always close a run
    `LZBD_ASSERT_NOW(a_close_run, o_out_valid && (o_kind == KIND_DONE || o_kind == KIND_ERROR), o_last_of_run)

    // data results carry no code or total, errors carry a code
    `LZBD_ASSERT_NOW(a_fields_clean, o_out_valid && o_kind != KIND_DONE, (o_kind == KIND_DATA) ? (o_error_code == ERR_NONE && o_total_length == '0) : (o_error_code != ERR_NONE))

endmodule

bind lz_block_decompressor lzbd_checker u_lzbd_checker (.*);

>>> verif/tb_top.sv
// testbench for the lz block decompressor: directed table, random containers, self-checking
`timescale 1ns / 1ps

module tb_top;
    import lzbd_pkg::*;

    localparam int HIST_DEPTH   = 2048;
    localparam int MIN_MATCH    = 3;
    localparam int DRAIN_CYCLES = 32;
    localparam int QUIET_LIMIT  = 5000;

    typedef struct packed {
        t_kind        kind;
        logic [7:0]   data;
        logic [2:0]   code;
        logic [23:0]  total;
        logic         tail;
    } t_result;

    typedef struct {
        logic [7:0]   data;
        logic         fin;
        logic         known;
        t_kind        kind;
        logic [2:0]   code;
        logic [23:0]  total;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [23:0]  i_cfg_output_capacity = '0;
    logic         i_in_valid = 1'b0;
    logic         o_in_ready;
    logic [7:0]   i_in_byte = '0;
    logic         i_last = 1'b0;
    logic         o_out_valid;
    logic         i_out_ready = 1'b0;
    logic [1:0]   o_kind;
    logic [7:0]   o_out_byte;
    logic [2:0]   o_error_code;
    logic [23:0]  o_total_length;
    logic         o_last_of_run;

    // decoder state as seen by the predictor
    logic [7:0]   hist [HIST_DEPTH];
    logic [23:0]  cap_limit;
    t_phase       ph;
    logic [1:0]   hdr_idx;
    logic [15:0]  raw_sz, packed_sz, consumed, blk_written;
    logic [23:0]  tot_written;
    logic [6:0]   lit_left;
    logic [7:0]   tag_hold;
    logic         stored, stream_failed, fin_item;
    logic [2:0]   first_err;

    t_result      item_results[$];
    t_result      pending_results[$];
    t_row         directed_rows[$];
    logic [7:0]   container[$];

    int unsigned  send_idle_pct = 30;
    int unsigned  recv_idle_pct = 67;
    int unsigned  mismatch_count = 0;
    int unsigned  quiet_cycles = 0;

    lz_block_decompressor uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_output_capacity (i_cfg_output_capacity),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_in_byte             (i_in_byte),
        .i_last                (i_last),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_kind                (o_kind),
        .o_out_byte            (o_out_byte),
        .o_error_code          (o_error_code),
        .o_total_length        (o_total_length),
        .o_last_of_run         (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_result result_of(t_kind k, logic [7:0] d, logic [2:0] c,
                                          logic [23:0] t, logic tail);
        t_result r;
        r.kind  = k;
        r.data  = d;
        r.code  = c;
        r.total = t;
        r.tail  = tail;
        return r;
    endfunction

    task automatic clear_stream();
        ph            = PH_HEADER;
        hdr_idx       = '0;
        raw_sz        = '0;
        packed_sz     = '0;
        consumed      = '0;
        blk_written   = '0;
        tot_written   = '0;
        lit_left      = '0;
        tag_hold      = '0;
        stored        = 1'b0;
        stream_failed = 1'b0;
        first_err     = ERR_NONE;
    endtask

    task automatic flag_error(input logic [2:0] code);
        stream_failed = 1'b1;
        if (first_err == ERR_NONE)
            first_err = code;
        if (!fin_item)
            item_results.push_back(result_of(KIND_ERROR, 8'h00, code, '0, 1'b0));
    endtask

    task automatic emit(input logic [7:0] b);
        hist[int'(blk_written) % HIST_DEPTH] = b;
        blk_written = blk_written + 16'd1;
        tot_written = tot_written + 24'd1;
        item_results.push_back(result_of(KIND_DATA, b, ERR_NONE, '0, 1'b0));
    endtask

    task automatic check_room(input int unsigned n, output bit ok);
        ok = 1'b0;
        if (32'(tot_written) + n > 32'(cap_limit))
            flag_error(ERR_CAPACITY);
        else if (32'(blk_written) + n > 32'(raw_sz))
            flag_error(ERR_LENGTH);
        else
            ok = 1'b1;
    endtask

    task automatic close_token();
        if (consumed >= packed_sz) begin
            if (blk_written != raw_sz)
                flag_error(ERR_LENGTH);
            else
                ph = PH_HEADER;
        end else begin
            ph = PH_TAG;
        end
    endtask

    // works out the results caused by one container byte
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        bit          ok;
        int unsigned len;
        logic [10:0] off;
        fin_item = fin;
        item_results.delete();
        if (!stream_failed) begin
            case (ph)
                PH_STORED: begin
                    consumed = consumed + 16'd1;
                    if (32'(tot_written) + 1 > 32'(cap_limit)) begin
                        flag_error(ERR_CAPACITY);
                    end else begin
                        emit(b);
                        if (consumed >= packed_sz)
                            ph = PH_HEADER;
                    end
                end
                PH_TAG: begin
                    consumed = consumed + 16'd1;
                    if (b[7]) begin
                        if (consumed >= packed_sz) begin
                            flag_error(ERR_TOKEN);
                        end else begin
                            tag_hold = b;
                            ph = PH_MATCH;
                        end
                    end else if (b == 8'h00) begin
                        if (blk_written != raw_sz)
                            flag_error(ERR_LENGTH);
                        else
                            ph = (consumed >= packed_sz) ? PH_HEADER : PH_SKIP;
                    end else if (32'(consumed) + 32'(b) > 32'(packed_sz)) begin
                        flag_error(ERR_TOKEN);
                    end else begin
                        check_room(32'(b), ok);
                        if (ok) begin
                            lit_left = b[6:0];
                            ph = PH_LITERAL;
                        end
                    end
                end
                PH_LITERAL: begin
                    consumed = consumed + 16'd1;
                    emit(b);
                    lit_left = lit_left - 7'd1;
                    if (lit_left == '0)
                        close_token();
                end
                PH_MATCH: begin
                    consumed = consumed + 16'd1;
                    len = 32'(tag_hold[6:3]) + MIN_MATCH;
                    off = {tag_hold[2:0], b};
                    if (off == '0 || 16'(off) > blk_written) begin
                        flag_error(ERR_OFFSET);
                    end else begin
                        check_room(len, ok);
                        if (ok) begin
                            repeat (len)
                                emit(hist[int'(blk_written - 16'(off)) % HIST_DEPTH]);
                            close_token();
                        end
                    end
                end
                PH_SKIP: begin
                    consumed = consumed + 16'd1;
                    if (consumed >= packed_sz)
                        ph = PH_HEADER;
                end
                default: begin
                    case (hdr_idx)
                        2'd0: raw_sz = {8'h00, b};
                        2'd1: raw_sz[15:8] = b;
                        2'd2: packed_sz = {8'h00, b};
                        default: packed_sz[15:8] = b;
                    endcase
                    if (hdr_idx != 2'd3) begin
                        hdr_idx = hdr_idx + 2'd1;
                        ph = PH_HEADER;
                    end else begin
                        hdr_idx = '0;
                        if (packed_sz == '0) begin
                            flag_error(ERR_ZERO_SIZE);
                        end else if (32'(tot_written) + 32'(raw_sz) > 32'(cap_limit)) begin
                            flag_error(ERR_CAPACITY);
                        end else begin
                            blk_written = '0;
                            consumed = '0;
                            stored = (raw_sz == packed_sz);
                            ph = stored ? PH_STORED : PH_TAG;
                        end
                    end
                end
            endcase
        end
        if (fin) begin
            if (!stream_failed && ph != PH_HEADER)
                flag_error(ERR_TRUNCATED);
            item_results.push_back(result_of(KIND_DONE, 8'h00, first_err, tot_written, 1'b0));
            clear_stream();
        end
        if (item_results.size() != 0)
            item_results[item_results.size() - 1].tail = 1'b1;
    endtask

    task automatic add_row(input logic [7:0] d, input logic fin, input logic known,
                           input t_kind k, input logic [2:0] c, input logic [23:0] t);
        directed_rows.push_back('{d, fin, known, k, c, t});
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic fin);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_last     <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_byte(b, fin);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [23:0] value);
        i_cfg_valid           <= 1'b1;
        i_cfg_output_capacity <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cap_limit = value;
    endtask

    // one container of one to three blocks, mostly well formed
    task automatic build_container();
        int unsigned written, len, off, lcode, cut;
        logic [7:0]  payload[$];
        container.delete();
        repeat ($urandom_range(1, 3)) begin
            payload.delete();
            written = 0;
            if ($urandom_range(3) == 0) begin
                len = $urandom_range(1, 8);
                repeat (len) payload.push_back(8'($urandom));
                written = len;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if (written == 0 || $urandom_range(1) == 0) begin
                        len = ($urandom_range(19) == 0) ? $urandom_range(100, 127)
                                                         : $urandom_range(1, 6);
                        payload.push_back(8'(len));
                        repeat (len) payload.push_back(8'($urandom));
                        written += len;
                    end else begin
                        lcode = $urandom_range(15);
                        off = $urandom_range(1, (written > 2047) ? 2047 : written);
                        payload.push_back(8'h80 | 8'(lcode << 3) | 8'(off >> 8));
                        payload.push_back(8'(off));
                        written += lcode + MIN_MATCH;
                    end
                end
                if ($urandom_range(4) == 0) begin
                    payload.push_back(8'h00);
                    repeat ($urandom_range(3)) payload.push_back(8'($urandom));
                end
            end
            container.push_back(8'(written));
            container.push_back(8'(written >> 8));
            container.push_back(8'(payload.size()));
            container.push_back(8'(payload.size() >> 8));
            foreach (payload[i]) container.push_back(payload[i]);
        end
        // broken endings and noise
        case ($urandom_range(9))
            0: repeat ($urandom_range(1, 3)) container.push_back(8'($urandom));
            1: begin
                cut = $urandom_range(1, container.size() - 1);
                repeat (cut) void'(container.pop_back());
            end
            2: container[$urandom_range(container.size() - 1)] = 8'($urandom);
            3: begin
                container.delete();
                repeat ($urandom_range(1, 12)) container.push_back(8'($urandom));
            end
            default: ;
        endcase
    endtask

    // the last container of a run is cut short where the item budget runs out
    task automatic run_random(input logic [23:0] capacity, input int unsigned s_idle,
                              input int unsigned r_idle, input int unsigned budget);
        int unsigned sent_items;
        bit          fin;
        settle();
        write_capacity(capacity);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent_items = 0;
        while (sent_items < budget) begin
            build_container();
            foreach (container[i]) begin
                fin = (i == container.size() - 1) || (sent_items + 1 == budget);
                feed_byte(container[i], fin);
                sent_items++;
                foreach (item_results[k]) pending_results.push_back(item_results[k]);
                if (fin)
                    break;
            end
        end
    endtask

    task automatic note_mismatch(input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: expected kind %0d byte %02h code %0d total %0d tail %0b, %s",
                     $realtime, want.kind, want.data, want.code, want.total, want.tail,
                     $sformatf("got kind %0d byte %02h code %0d total %0d tail %0b",
                               got.kind, got.data, got.code, got.total, got.tail));
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (o_out_valid && i_out_ready) begin
                got.kind  = t_kind'(o_kind);
                got.data  = o_out_byte;
                got.code  = o_error_code;
                got.total = o_total_length;
                got.tail  = o_last_of_run;
                if (pending_results.size() == 0) begin
                    // result with nothing waiting
                    note_mismatch('0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        note_mismatch(want, got);
                end
            end
        end
    end

    initial begin
        wait (i_rst_n);
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        clear_stream();
        cap_limit = CAP_RESET;

        // empty stream
        add_row(8'h00, 1'b1, 1'b1, KIND_DONE, ERR_NONE, 24'd0);
        // zero packed size, then the rest ignored
        add_row(8'h00, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h00, 1'b0, 1'b1, KIND_ERROR, ERR_ZERO_SIZE, 24'd0);
        add_row(8'hFF, 1'b1, 1'b1, KIND_DONE, ERR_ZERO_SIZE, 24'd0);
        // stored block of one byte
        add_row(8'h01, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h01, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        // literal run then an overlapping match
        add_row(8'h06, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h05, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h02, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'hFF, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h80, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h88, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h01, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        // offset zero on the closing byte folds into done
        add_row(8'h03, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h02, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h80, 1'b0, 1'b0, KIND_DATA, ERR_NONE, 24'd0);
        add_row(8'h00, 1'b1, 1'b1, KIND_DONE, ERR_OFFSET, 24'd7);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            feed_byte(directed_rows[n].data, directed_rows[n].fin);
            if (directed_rows[n].known)
                pending_results.push_back(result_of(directed_rows[n].kind, 8'h00,
                                                    directed_rows[n].code,
                                                    directed_rows[n].total, 1'b1));
            else
                foreach (item_results[k]) pending_results.push_back(item_results[k]);
        end

        run_random(24'd0, 30, 67, 20);
        run_random(24'd30, 30, 67, 45);
        run_random(CAP_RESET, 67, 30, 80);
        run_random(24'd100, 0, 0, 50);
        run_random(24'd1, 0, 0, 30);
        settle();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
